// ===== hw/rtl/selectable_sensor_filter_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SELECTABLE_SENSOR_FILTER_MACROS_SVH
`define SELECTABLE_SENSOR_FILTER_MACROS_SVH

// Antecedent in one cycle, consequent in the next.
`define SSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("selectable_sensor_filter: assertion failed");

// Antecedent and consequent in the same cycle.
`define SSF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("selectable_sensor_filter: assertion failed");

// State right after a reset cycle; reset itself is the antecedent.
`define SSF_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("selectable_sensor_filter: reset assertion failed");

`endif

// ===== hw/rtl/ssf_pkg.sv =====
`timescale 1ns / 1ps
package ssf_pkg;

   localparam logic [1:0] MODE_LOWPASS = 2'd0;
   localparam logic [1:0] MODE_AVERAGE = 2'd1;
   localparam logic [1:0] MODE_MEDIAN  = 2'd2;
   localparam logic [1:0] MODE_PASS    = 2'd3;

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_LENGTH = 2'd1;
   localparam logic [1:0] CSR_WEIGHT = 2'd2;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   localparam int CSR_DATA_WIDTH = 17;
   localparam int WEIGHT_SHIFT   = 16;
   localparam logic [16:0] WEIGHT_ONE = 17'h10000;

   localparam logic [1:0]  RESET_MODE   = MODE_PASS;
   localparam logic [4:0]  RESET_LENGTH = 5'd5;
   localparam logic [16:0] RESET_WEIGHT = 17'h08000;

   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } mem_ctl_type;

endpackage

// ===== hw/rtl/selectable_sensor_filter.sv =====
`timescale 1ns / 1ps
// Filters signed sensor samples, one result per request, in one of four modes chosen by
// register 0: exponential low-pass, moving average, median or pass-through; a clear request
// zeroes the window, write position and low-pass state and returns 0. All window access goes
// through one history memory with one write port and a registered read port, and a small
// sequencer reuses one compare/accumulate path. Moving average makes one memory read per
// entry, then runs a bit-serial divider; median ranks every entry against every other one
// through the memory read port. The block takes a new request once the previous result sits
// in the output register.
module selectable_sensor_filter import ssf_pkg::*; #(
   parameter int WINDOW_MAX   = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_wdata
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int AW    = $clog2(WINDOW_MAX);
   localparam int LENW  = $clog2(WINDOW_MAX + 1);
   localparam int LW    = (LENW > 5) ? LENW : 5;
   localparam int SUMW  = SW + AW + 1;
   localparam int PRODW = 18 + SW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_WRITE, ST_SUM, ST_DIV, ST_MSCAN, ST_MFIN, ST_LPMUL, ST_LPADD, ST_OUT
   } state_type;

   typedef struct packed {
      logic            valid;
      logic            cand;
      logic            last;
      logic            fin;
      logic [LENW-1:0] idx;
   } pend_type;

   state_type             state_ff, state_in;
   logic [1:0]            mode_ff;
   logic [4:0]            wlen_ff;
   logic [16:0]           weight_ff;
   logic signed [SW-1:0]  x_ff, x_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic signed [SW-1:0]  smoothed_ff, smoothed_in;
   logic [LENW-1:0]       cnt_ff, cnt_in;
   logic [LENW-1:0]       i_ff, i_in;
   logic                  iss_done_ff, iss_done_in;
   pend_type              pend_ff, pend_in;
   logic signed [SUMW-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic signed [SW-1:0]  cand_ff, cand_in;
   logic [LENW-1:0]       cidx_ff, cidx_in;
   logic [LENW-1:0]       rank_ff, rank_in;
   logic signed [SW-1:0]  lo_ff, lo_in;
   logic signed [SW-1:0]  hi_ff, hi_in;
   logic signed [PRODW-1:0] prod_ff, prod_in;
   logic signed [SW-1:0]  res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]  rsp_data_ff, rsp_data_in;

   logic [LW-1:0]         wl_ext;
   logic [LW-1:0]         len_w;
   logic [LENW-1:0]       len;
   logic [LENW-1:0]       lo_k;
   logic [LENW-1:0]       hi_k;
   logic [LENW-1:0]       wr_p;
   logic [LENW-1:0]       wr_p1;
   logic                  accept;
   logic                  iss_en;
   logic [LENW-1:0]       iss_addr;
   logic                  iss_last;
   logic                  lt;
   logic [LENW-1:0]       rank_new;
   logic signed [SUMW-1:0] sum_new;
   logic [SUMW-1:0]       sum_mag;
   logic [16:0]           a_sat;
   logic signed [17:0]    a_s;
   logic signed [SW:0]    diff;
   logic signed [PRODW-1:0] step;
   logic signed [SW:0]    mid_sum;
   logic                  div_start;
   logic                  div_done;
   logic [SUMW-1:0]       div_quo;
   logic [SUMW-1:0]       quo_signed;
   mem_ctl_type           mem_ctl;
   logic signed [SW-1:0]  mem_rdata;

   ssf_hist_mem #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_hist_mem (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mem_ctl),
      .wr_addr(wr_p[AW-1:0]),
      .wr_data(x_ff),
      .rd_addr(iss_addr[AW-1:0]),
      .rd_data(mem_rdata)
   );

   ssf_divider #(
      .NW(SUMW),
      .DW(LENW)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(sum_mag),
      .divisor (len),
      .done    (div_done),
      .quotient(div_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // Clamp the window length to 1..WINDOW_MAX.
   always_comb begin
      wl_ext = LW'(wlen_ff);
      if (wl_ext == '0) begin
         len_w = LW'(1);
      end else if (wl_ext > LW'(WINDOW_MAX)) begin
         len_w = LW'(WINDOW_MAX);
      end else begin
         len_w = wl_ext;
      end
      len  = len_w[LENW-1:0];
      lo_k = (len - 1'b1) >> 1;
      hi_k = len >> 1;
   end

   // Write slot; a stale position from a longer window restarts at entry 0.
   always_comb begin
      wr_p  = (LENW'(pos_ff) >= len) ? '0 : LENW'(pos_ff);
      wr_p1 = wr_p + 1'b1;
   end

   always_comb begin
      mem_ctl.wr_en     = (state_ff == ST_WRITE);
      mem_ctl.clear_all = accept && (req_type == REQ_CLEAR);
   end

   // Read issue: sum walks the window once, median reads each candidate then the whole window.
   always_comb begin
      iss_en   = ((state_ff == ST_SUM) || (state_ff == ST_MSCAN)) && !iss_done_ff;
      iss_addr = cnt_ff;
      iss_last = (cnt_ff == len - 1'b1);
      if (state_ff == ST_MSCAN) begin
         iss_addr = (cnt_ff == '0) ? i_ff : cnt_ff - 1'b1;
         iss_last = (cnt_ff == len);
      end
   end

   always_comb begin
      lt       = (mem_rdata < cand_ff) || ((mem_rdata == cand_ff) && (pend_ff.idx < cidx_ff));
      rank_new = rank_ff + LENW'(lt);
      sum_new  = acc_ff + SUMW'(mem_rdata);
      sum_mag  = sum_new[SUMW-1] ? SUMW'(-sum_new) : SUMW'(sum_new);
      a_sat    = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
      a_s      = $signed({1'b0, a_sat});
      diff     = (SW+1)'(x_ff) - (SW+1)'(smoothed_ff);
      step     = prod_ff >>> WEIGHT_SHIFT;
      mid_sum  = (SW+1)'(lo_ff) + (SW+1)'(hi_ff);
      quo_signed = neg_ff ? SUMW'(-div_quo) : div_quo;
      div_start  = (state_ff == ST_SUM) && pend_ff.valid && pend_ff.last;
   end

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      pos_in      = pos_ff;
      smoothed_in = smoothed_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      iss_done_in = iss_done_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      cand_in     = cand_ff;
      cidx_in     = cidx_ff;
      rank_in     = rank_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      prod_in     = prod_ff;
      res_in      = res_ff;
      pend_in     = '{valid: iss_en, cand: (state_ff == ST_MSCAN) && (cnt_ff == '0),
                      last: iss_last, fin: iss_last && (i_ff == len - 1'b1), idx: iss_addr};

      // Advance the read counters.
      if (iss_en) begin
         if (iss_last) begin
            cnt_in = '0;
            i_in   = i_ff + 1'b1;
            if (state_ff == ST_SUM || i_ff == len - 1'b1) begin
               iss_done_in = 1'b1;
            end
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in = req_sample;
               if (req_type == REQ_CLEAR) begin
                  pos_in      = '0;
                  smoothed_in = '0;
                  res_in      = '0;
                  state_in    = ST_OUT;
               end else begin
                  unique case (mode_ff) inside
                     MODE_LOWPASS: state_in = ST_LPMUL;
                     MODE_AVERAGE, MODE_MEDIAN: state_in = ST_WRITE;
                     default: begin
                        res_in   = req_sample;
                        state_in = ST_OUT;
                     end
                  endcase
               end
            end
         end
         ST_WRITE: begin
            pos_in      = (wr_p1 >= len) ? '0 : wr_p1[AW-1:0];
            cnt_in      = '0;
            i_in        = '0;
            iss_done_in = 1'b0;
            acc_in      = '0;
            state_in    = (mode_ff == MODE_AVERAGE) ? ST_SUM : ST_MSCAN;
         end
         ST_SUM: begin
            if (pend_ff.valid) begin
               acc_in = sum_new;
               if (pend_ff.last) begin
                  neg_in   = sum_new[SUMW-1];
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = quo_signed[SW-1:0];
               state_in = ST_OUT;
            end
         end
         ST_MSCAN: begin
            if (pend_ff.valid) begin
               if (pend_ff.cand) begin
                  cand_in = mem_rdata;
                  cidx_in = pend_ff.idx;
                  rank_in = '0;
               end else begin
                  rank_in = rank_new;
                  if (pend_ff.last) begin
                     if (rank_new == lo_k) begin
                        lo_in = cand_ff;
                     end
                     if (rank_new == hi_k) begin
                        hi_in = cand_ff;
                     end
                     if (pend_ff.fin) begin
                        state_in = ST_MFIN;
                     end
                  end
               end
            end
         end
         ST_MFIN: begin
            res_in   = mid_sum[SW:1];
            state_in = ST_OUT;
         end
         ST_LPMUL: begin
            prod_in  = a_s * diff;
            state_in = ST_LPADD;
         end
         ST_LPADD: begin
            smoothed_in = smoothed_ff + step[SW-1:0];
            res_in      = smoothed_ff + step[SW-1:0];
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: hold until taken, load from the sequencer when the slot frees up.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= RESET_MODE;
         wlen_ff      <= RESET_LENGTH;
         weight_ff    <= RESET_WEIGHT;
         pos_ff       <= '0;
         smoothed_ff  <= '0;
         cnt_ff       <= '0;
         i_ff         <= '0;
         iss_done_ff  <= 1'b1;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         smoothed_ff  <= smoothed_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         iss_done_ff  <= iss_done_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODE:   mode_ff   <= csr_wdata[1:0];
               CSR_LENGTH: wlen_ff   <= csr_wdata[4:0];
               CSR_WEIGHT: weight_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      cand_ff     <= cand_in;
      cidx_ff     <= cidx_in;
      rank_ff     <= rank_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_data_ff;

endmodule

// ===== hw/rtl/ssf_hist_mem.sv =====
`timescale 1ns / 1ps
module ssf_hist_mem import ssf_pkg::*; #(
   parameter int WINDOW_MAX   = 16,
   parameter int SAMPLE_WIDTH = 16,
   localparam int AW = $clog2(WINDOW_MAX)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mem_ctl_type                    ctl,
   input  logic [AW-1:0]                  wr_addr,
   input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output logic signed [SAMPLE_WIDTH-1:0] rd_data
);

   logic signed [SAMPLE_WIDTH-1:0] mem [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]          valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear_all) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Entries never written since the last clear read as zero.
   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ssf_divider.sv =====
`timescale 1ns / 1ps
module ssf_divider #(
   parameter int NW = 21,
   parameter int DW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CW = $clog2(NW + 1);

   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW:0]   trial;
   logic          fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      trial     = {rem_ff, quo_ff[NW-1]};
      fits      = trial >= {1'b0, div_ff};
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CW'(NW);
         div_in    = divisor;
         rem_in    = '0;
         quo_in    = dividend;
      end else if (active_ff) begin
         rem_in = fits ? DW'(trial - {1'b0, div_ff}) : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/ssf_checker.sv =====
`timescale 1ns / 1ps
`include "selectable_sensor_filter_macros.svh"
module ssf_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_filtered
);

   // A stalled result holds.
   `SSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_filtered))
   // Every accepted transaction leaves the sequencer busy in the next cycle.
   `SSF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // A new result lands as the sequencer returns to idle.
   `SSF_ASSERT_SAME(a_rsp_with_idle, clock, reset, $rose(rsp_valid), req_ready)
   `SSF_ASSERT_RESET(a_reset_state, clock, reset, !rsp_valid && req_ready)

endmodule

bind selectable_sensor_filter ssf_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ssf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_filtered(rsp_filtered)
);
